// File: rtl/pcld_pkg.sv
// Shared types and constants for the per-CPU lockup detector.
// Holds the opcode codes, the per-CPU memory entry layout and limit constants.
// No dependencies.
package pcld_pkg;

   // Field widths
   localparam int TIME_W       = 64;
   localparam int CPU_IDX_W    = 6;
   localparam int OPCODE_W     = 3;
   localparam int THRESH_W     = 6;
   localparam int COARSE_SHIFT = 30;
   localparam int COARSE_W     = TIME_W - COARSE_SHIFT;

   // Default number of CPUs tracked
   localparam int DEFAULT_NUM_CPUS = 64;

   // Opcodes
   localparam logic [OPCODE_W-1:0] OP_PROFILE = 3'd0;
   localparam logic [OPCODE_W-1:0] OP_EXPIRY  = 3'd1;
   localparam logic [OPCODE_W-1:0] OP_START   = 3'd2;
   localparam logic [OPCODE_W-1:0] OP_CANCEL  = 3'd3;
   localparam logic [OPCODE_W-1:0] OP_SCHED   = 3'd4;

   // Threshold and derived limits
   localparam logic [THRESH_W-1:0] THRESH_RESET = 6'd10;
   localparam int FIFTH_W = 28;
   localparam logic [FIFTH_W-1:0] FIFTH_SECOND_NS = 28'd200000000;
   // (2*63+1)*2e8 fits in 35 bits
   localparam int HARD_LIMIT_W = 35;
   // floor(126/5) = 25 fits in 5 bits
   localparam int SOFT_LIMIT_W = 5;
   // x/5 == (x*205)>>10 for every x up to 126
   localparam int RECIP_W     = 8;
   localparam logic [RECIP_W-1:0] RECIP_FIVE = 8'd205;
   localparam int RECIP_SHIFT = 10;

   // worked out at 64 bits, the product does not fit in an int
   localparam logic [HARD_LIMIT_W-1:0] HARD_LIMIT_RESET =
      HARD_LIMIT_W'((64'(THRESH_RESET) * 64'd2 + 64'd1) * 64'(FIFTH_SECOND_NS));
   localparam logic [SOFT_LIMIT_W-1:0] SOFT_LIMIT_RESET =
      SOFT_LIMIT_W'((int'(THRESH_RESET) * 2) / 5);

   // One CPU's state as held in memory
   typedef struct packed {
      logic                running;
      logic [TIME_W-1:0]   touch;
      logic [COARSE_W-1:0] sched;
      logic                ticked;
      logic                hard;
      logic                soft_lock;
   } cpu_entry_type;

endpackage

// File: rtl/per_cpu_lockup_detector_unit.sv
// Top level of the per-CPU lockup detector; uses pcld_pkg.
// Requests pass through stage 1 (state memory read) and the response register.
// Throughput: one request per cycle while the response channel is not stalled;
// a request to the CPU written the cycle before is served by forwarding, so the
// read-modify-write needs no interlock. Reset: limits return to defaults, then a
// clearing sweep writes zero to every entry with req_ready held low.
module per_cpu_lockup_detector_unit
   import pcld_pkg::*;
#(
   parameter int NUM_CPUS = DEFAULT_NUM_CPUS
) (
   input  logic                clock,
   input  logic                reset,
   // request channel
   input  logic                req_valid,
   output logic                req_ready,
   input  logic [OPCODE_W-1:0] req_opcode,
   input  logic [CPU_IDX_W-1:0] req_cpu_index,
   input  logic [TIME_W-1:0]   req_time_ns,
   // response channel
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic                rsp_hard_lockup_warn,
   output logic                rsp_soft_lockup_warn,
   output logic                rsp_show_event,
   // threshold register
   input  logic                csr_wr_en,
   input  logic [THRESH_W-1:0] csr_wr_data
);

   localparam int IDX_W = (NUM_CPUS > 1) ? $clog2(NUM_CPUS) : 1;
   localparam int EXT_W = (IDX_W > CPU_IDX_W) ? IDX_W : CPU_IDX_W;

   // Limits, recomputed on each threshold write
   logic [HARD_LIMIT_W-1:0]        hard_limit_ff;
   logic [SOFT_LIMIT_W-1:0]        soft_limit_ff;
   logic [THRESH_W:0]              twice_plus_one;
   logic [THRESH_W:0]              twice;
   logic [THRESH_W+RECIP_W:0]      fifth_prod;
   logic [HARD_LIMIT_W-1:0]        hard_limit_in;

   assign twice_plus_one = {csr_wr_data, 1'b1};
   assign twice          = {csr_wr_data, 1'b0};
   assign hard_limit_in  = HARD_LIMIT_W'(twice_plus_one) * HARD_LIMIT_W'(FIFTH_SECOND_NS);
   assign fifth_prod     = (THRESH_W+RECIP_W+1)'(twice) * (THRESH_W+RECIP_W+1)'(RECIP_FIVE);

   always_ff @(posedge clock) begin
      if (reset) begin
         hard_limit_ff <= HARD_LIMIT_RESET;
         soft_limit_ff <= SOFT_LIMIT_RESET;
      end else if (csr_wr_en) begin
         hard_limit_ff <= hard_limit_in;
         soft_limit_ff <= fifth_prod[RECIP_SHIFT +: SOFT_LIMIT_W];
      end
   end

   // Clearing sweep after reset
   logic             clearing_ff;
   logic [IDX_W-1:0] clear_cnt_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         clearing_ff  <= 1'b1;
         clear_cnt_ff <= '0;
      end else if (clearing_ff) begin
         clear_cnt_ff <= clear_cnt_ff + 1'b1;
         if (clear_cnt_ff == IDX_W'(NUM_CPUS - 1)) begin
            clearing_ff <= 1'b0;
         end
      end
   end

   // Handshake and stage control
   logic rsp_valid_ff;
   logic s1_valid_ff;
   logic s1_advance;
   logic s1_write;
   logic req_accept;

   assign s1_advance = !rsp_valid_ff || rsp_ready;
   assign req_ready  = !clearing_ff && (!s1_valid_ff || s1_advance);
   assign req_accept = req_valid && req_ready;

   // Request decode
   logic [EXT_W-1:0] req_idx_ext;
   logic [IDX_W-1:0] req_addr;
   logic             req_in_range;

   assign req_idx_ext  = EXT_W'(req_cpu_index);
   assign req_addr     = req_idx_ext[IDX_W-1:0];
   assign req_in_range = 32'(req_cpu_index) < NUM_CPUS;

   // Stage 1 payload
   logic [OPCODE_W-1:0] s1_op_ff;
   logic [IDX_W-1:0]    s1_addr_ff;
   logic [TIME_W-1:0]   s1_time_ff;
   logic                s1_in_range_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req_accept) begin
         s1_valid_ff <= 1'b1;
      end else if (s1_advance) begin
         s1_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         s1_op_ff       <= req_opcode;
         s1_addr_ff     <= req_addr;
         s1_time_ff     <= req_time_ns;
         s1_in_range_ff <= req_in_range;
      end
   end

   // Per-CPU state memory with a registered read
   cpu_entry_type cpu_mem [NUM_CPUS];
   cpu_entry_type mem_rdata_ff;
   cpu_entry_type mem_wdata;
   logic          mem_we;
   logic [IDX_W-1:0] mem_waddr;
   cpu_entry_type nxt_entry;

   assign s1_write  = s1_valid_ff && s1_advance && s1_in_range_ff;
   assign mem_we    = clearing_ff || s1_write;
   assign mem_waddr = clearing_ff ? clear_cnt_ff : s1_addr_ff;
   assign mem_wdata = clearing_ff ? '0 : nxt_entry;

   always_ff @(posedge clock) begin
      if (mem_we) begin
         cpu_mem[mem_waddr] <= mem_wdata;
      end
      if (req_accept) begin
         mem_rdata_ff <= cpu_mem[req_addr];
      end
   end

   // Forwarding of an entry written while the next request was read
   logic          fwd_hit_ff;
   cpu_entry_type fwd_entry_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         fwd_hit_ff <= 1'b0;
      end else if (req_accept) begin
         fwd_hit_ff <= s1_write && (s1_addr_ff == req_addr);
      end
   end

   always_ff @(posedge clock) begin
      if (s1_write) begin
         fwd_entry_ff <= nxt_entry;
      end
   end

   // Event update and lockup checks
   cpu_entry_type       cur_entry;
   logic [COARSE_W-1:0] now_coarse;
   logic [TIME_W-1:0]   hard_delta;
   logic [TIME_W-1:0]   soft_delta;
   logic                show;

   assign cur_entry  = fwd_hit_ff ? fwd_entry_ff : mem_rdata_ff;
   assign now_coarse = s1_time_ff[TIME_W-1:COARSE_SHIFT];
   assign hard_delta = s1_time_ff - cur_entry.touch;
   assign soft_delta = TIME_W'(now_coarse) - TIME_W'(cur_entry.sched);

   always_comb begin
      nxt_entry = cur_entry;
      show      = cur_entry.soft_lock;
      unique case (s1_op_ff)
         OP_PROFILE: begin
            nxt_entry.hard   = cur_entry.running && (|cur_entry.touch) &&
                               !cur_entry.ticked &&
                               (hard_delta > TIME_W'(hard_limit_ff));
            nxt_entry.ticked = 1'b0;
            show             = nxt_entry.hard || cur_entry.soft_lock;
         end
         OP_EXPIRY: begin
            nxt_entry.running   = 1'b1;
            nxt_entry.ticked    = 1'b1;
            nxt_entry.touch     = s1_time_ff;
            nxt_entry.soft_lock = (|cur_entry.sched) &&
                                  (soft_delta > TIME_W'(soft_limit_ff));
            show                = nxt_entry.soft_lock;
         end
         OP_START: begin
            nxt_entry.running = 1'b1;
            nxt_entry.touch   = s1_time_ff;
         end
         OP_CANCEL: begin
            nxt_entry.running = 1'b0;
         end
         OP_SCHED: begin
            nxt_entry.sched = now_coarse;
         end
         default: begin
            nxt_entry = cur_entry;
         end
      endcase
   end

   // Response register
   logic rsp_hard_ff;
   logic rsp_soft_ff;
   logic rsp_show_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (s1_advance) begin
         rsp_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_valid_ff && s1_advance) begin
         rsp_hard_ff <= s1_in_range_ff && nxt_entry.hard;
         rsp_soft_ff <= s1_in_range_ff && nxt_entry.soft_lock;
         rsp_show_ff <= s1_in_range_ff && show;
      end
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_hard_lockup_warn = rsp_hard_ff;
   assign rsp_soft_lockup_warn = rsp_soft_ff;
   assign rsp_show_event       = rsp_show_ff;

endmodule

// File: rtl/pcld_checker.sv
// Port-level checks for the per-CPU lockup detector.
// Attached to per_cpu_lockup_detector_unit by the bind at the end of this file.
module pcld_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_ready,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic       rsp_hard_lockup_warn,
   input logic       rsp_soft_lockup_warn,
   input logic       rsp_show_event
);

   // req_ready is low right after reset, while the state memory is being cleared
   a_clear_after_reset: assert property (@(posedge clock)
      reset |=> !req_ready)
      else $error("request ready during clearing sweep");

   // A soft warning is always reported
   a_soft_shown: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_soft_lockup_warn |-> rsp_show_event)
      else $error("soft lockup flag without show_event");

   // Nothing is reported without a flag set
   a_show_needs_flag: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_show_event |-> (rsp_hard_lockup_warn || rsp_soft_lockup_warn))
      else $error("show_event without any lockup flag");

   // A stalled response holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_hard_lockup_warn) &&
         $stable(rsp_soft_lockup_warn) && $stable(rsp_show_event))
      else $error("stalled response changed");

endmodule

bind per_cpu_lockup_detector_unit pcld_checker u_pcld_checker (.*);

// File: tb/sv/pcld_lockup_checker.sv
// Scoreboard for the per-CPU lockup detector: watches the request, response and
// threshold ports, predicts each response and compares it field by field.
// Depends on pcld_pkg for widths, opcodes and limit constants.
module pcld_lockup_checker
   import pcld_pkg::*;
#(
   parameter int NUM_CPUS = DEFAULT_NUM_CPUS
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   input  logic                 req_ready,
   input  logic [OPCODE_W-1:0]  req_opcode,
   input  logic [CPU_IDX_W-1:0] req_cpu_index,
   input  logic [TIME_W-1:0]    req_time_ns,
   input  logic                 rsp_valid,
   input  logic                 rsp_ready,
   input  logic                 rsp_hard_lockup_warn,
   input  logic                 rsp_soft_lockup_warn,
   input  logic                 rsp_show_event,
   input  logic                 csr_wr_en,
   input  logic [THRESH_W-1:0]  csr_wr_data,
   output int                   mismatches,
   output int                   pending,
   output int                   checked,
   output int                   hard_hits,
   output int                   soft_hits
);

   // Expected response, with the request it came from for reporting
   typedef struct {
      logic [OPCODE_W-1:0]  op;
      logic [CPU_IDX_W-1:0] cpu;
      logic                 hard;
      logic                 soft_warn;
      logic                 show;
   } lockup_verdict_type;

   lockup_verdict_type verdict_q[$];

   // Shadow copy of the per-CPU watchdog state
   logic                running      [NUM_CPUS];
   logic [TIME_W-1:0]   touch_ns     [NUM_CPUS];
   logic [COARSE_W-1:0] sched_coarse [NUM_CPUS];
   logic                ticked       [NUM_CPUS];
   logic                hard_flag    [NUM_CPUS];
   logic                soft_flag    [NUM_CPUS];
   logic [THRESH_W-1:0] thresh;

   // Apply one event to the shadow state and return the flags it leaves
   function automatic lockup_verdict_type judge_event(input logic [OPCODE_W-1:0]  op,
                                                      input logic [CPU_IDX_W-1:0] cpu,
                                                      input logic [TIME_W-1:0]    now);
      lockup_verdict_type v;
      logic [TIME_W-1:0] soft_lim;
      logic [TIME_W-1:0] hard_lim;
      logic [TIME_W-1:0] coarse_now;
      soft_lim   = (64'(thresh) * 64'd2) / 64'd5;
      hard_lim   = (64'(thresh) * 64'd2 + 64'd1) * 64'(FIFTH_SECOND_NS);
      coarse_now = now >> COARSE_SHIFT;
      v.op        = op;
      v.cpu       = cpu;
      v.hard      = 1'b0;
      v.soft_warn = 1'b0;
      v.show      = 1'b0;
      // events for CPUs beyond the table are dropped and report nothing
      if (int'(cpu) >= NUM_CPUS)
         return v;
      case (op)
         OP_PROFILE: begin
            hard_flag[cpu] = running[cpu] && (touch_ns[cpu] != '0) && !ticked[cpu] &&
                             ((now - touch_ns[cpu]) > hard_lim);
            ticked[cpu] = 1'b0;
         end
         OP_EXPIRY: begin
            running[cpu]  = 1'b1;
            ticked[cpu]   = 1'b1;
            touch_ns[cpu] = now;
            // difference wraps at 64 bits, so a scheduler touch in the future counts
            soft_flag[cpu] = (sched_coarse[cpu] != '0) &&
                             ((coarse_now - 64'(sched_coarse[cpu])) > soft_lim);
         end
         OP_START: begin
            running[cpu]  = 1'b1;
            touch_ns[cpu] = now;
         end
         OP_CANCEL: begin
            running[cpu] = 1'b0;
         end
         OP_SCHED: begin
            sched_coarse[cpu] = coarse_now[COARSE_W-1:0];
         end
         default: begin
         end
      endcase
      v.hard      = hard_flag[cpu];
      v.soft_warn = soft_flag[cpu];
      v.show      = (op == OP_PROFILE) ? (v.hard || v.soft_warn) : v.soft_warn;
      return v;
   endfunction

   function automatic void check_field(input string name, input lockup_verdict_type v,
                                       input logic exp_bit, input logic act_bit);
      if (act_bit !== exp_bit) begin
         mismatches++;
         $display("%0t: cpu %0d op %0d %s mismatch: expected %0b, actual %0b",
                  $time, v.cpu, v.op, name, exp_bit, act_bit);
      end
   endfunction

   // Sample on the rising edge: requests first, then responses, then the threshold
   always @(posedge clock) begin
      lockup_verdict_type v;
      if (reset) begin
         for (int i = 0; i < NUM_CPUS; i++) begin
            running[i]      = 1'b0;
            touch_ns[i]     = '0;
            sched_coarse[i] = '0;
            ticked[i]       = 1'b0;
            hard_flag[i]    = 1'b0;
            soft_flag[i]    = 1'b0;
         end
         thresh = THRESH_RESET;
         verdict_q.delete();
         mismatches = 0;
         checked    = 0;
         hard_hits  = 0;
         soft_hits  = 0;
      end else begin
         if (req_valid && req_ready)
            verdict_q.push_back(judge_event(req_opcode, req_cpu_index, req_time_ns));
         if (rsp_valid && rsp_ready) begin
            if (verdict_q.size() == 0) begin
               mismatches++;
               $display("%0t: unexpected response: expected none, actual hard %0b soft %0b show %0b",
                        $time, rsp_hard_lockup_warn, rsp_soft_lockup_warn, rsp_show_event);
            end else begin
               v = verdict_q.pop_front();
               check_field("hard_lockup_warn", v, v.hard, rsp_hard_lockup_warn);
               check_field("soft_lockup_warn", v, v.soft_warn, rsp_soft_lockup_warn);
               check_field("show_event", v, v.show, rsp_show_event);
               checked++;
               hard_hits += int'(v.hard);
               soft_hits += int'(v.soft_warn);
            end
         end
         if (csr_wr_en)
            thresh = csr_wr_data;
      end
      pending = verdict_q.size();
   end

endmodule

// File: tb/sv/tb_per_cpu_lockup_detector_unit.sv
// Testbench top for per_cpu_lockup_detector_unit: clock, reset, request and
// threshold stimulus, response back-pressure and the final verdict.
// Depends on pcld_pkg, the detector RTL and pcld_lockup_checker.
module tb_per_cpu_lockup_detector_unit;
   import pcld_pkg::*;

   // opcodes with no defined action
   localparam logic [OPCODE_W-1:0] OP_UNUSED_LO = 3'd5;
   localparam logic [OPCODE_W-1:0] OP_UNUSED_HI = 3'd7;
   localparam int PHASES          = 8;
   localparam int ITEMS_PER_PHASE = 232;
   localparam int HOT_CPUS        = 4;

   logic                 clock         = 1'b0;
   logic                 reset         = 1'b1;
   logic                 req_valid     = 1'b0;
   logic [OPCODE_W-1:0]  req_opcode    = '0;
   logic [CPU_IDX_W-1:0] req_cpu_index = '0;
   logic [TIME_W-1:0]    req_time_ns   = '0;
   logic                 rsp_ready     = 1'b0;
   logic                 csr_wr_en     = 1'b0;
   logic [THRESH_W-1:0]  csr_wr_data   = '0;
   wire                  req_ready;
   wire                  rsp_valid;
   wire                  rsp_hard_lockup_warn;
   wire                  rsp_soft_lockup_warn;
   wire                  rsp_show_event;

   int mismatches;
   int pending;
   int checked;
   int hard_hits;
   int soft_hits;
   int idle_pct   = 20;
   int stall_left = 0;
   int sent       = 0;
   int csr_writes = 0;

   logic [TIME_W-1:0]    cpu_clock [DEFAULT_NUM_CPUS];
   logic [CPU_IDX_W-1:0] hot_cpu   [HOT_CPUS];
   logic [THRESH_W-1:0]  thresh_now = THRESH_RESET;

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   per_cpu_lockup_detector_unit #(
      .NUM_CPUS (DEFAULT_NUM_CPUS)
   ) u_top (
      .clock                (clock),
      .reset                (reset),
      .req_valid            (req_valid),
      .req_ready            (req_ready),
      .req_opcode           (req_opcode),
      .req_cpu_index        (req_cpu_index),
      .req_time_ns          (req_time_ns),
      .rsp_valid            (rsp_valid),
      .rsp_ready            (rsp_ready),
      .rsp_hard_lockup_warn (rsp_hard_lockup_warn),
      .rsp_soft_lockup_warn (rsp_soft_lockup_warn),
      .rsp_show_event       (rsp_show_event),
      .csr_wr_en            (csr_wr_en),
      .csr_wr_data          (csr_wr_data)
   );

   pcld_lockup_checker #(
      .NUM_CPUS (DEFAULT_NUM_CPUS)
   ) u_check (
      .clock                (clock),
      .reset                (reset),
      .req_valid            (req_valid),
      .req_ready            (req_ready),
      .req_opcode           (req_opcode),
      .req_cpu_index        (req_cpu_index),
      .req_time_ns          (req_time_ns),
      .rsp_valid            (rsp_valid),
      .rsp_ready            (rsp_ready),
      .rsp_hard_lockup_warn (rsp_hard_lockup_warn),
      .rsp_soft_lockup_warn (rsp_soft_lockup_warn),
      .rsp_show_event       (rsp_show_event),
      .csr_wr_en            (csr_wr_en),
      .csr_wr_data          (csr_wr_data),
      .mismatches           (mismatches),
      .pending              (pending),
      .checked              (checked),
      .hard_hits            (hard_hits),
      .soft_hits            (soft_hits)
   );

   // Response back-pressure: random stall bursts of random length
   always @(posedge clock) begin
      if (stall_left > 0) begin
         stall_left--;
         rsp_ready <= 1'b0;
      end else if (!reset && ($urandom_range(0, 99) < idle_pct / 2)) begin
         stall_left = $urandom_range(0, 15);
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   // Present one request and hold it until accepted, then maybe go quiet for a burst
   task automatic send_event(input logic [OPCODE_W-1:0]  op,
                             input logic [CPU_IDX_W-1:0] cpu,
                             input logic [TIME_W-1:0]    t);
      req_valid     <= 1'b1;
      req_opcode    <= op;
      req_cpu_index <= cpu;
      req_time_ns   <= t;
      do @(posedge clock); while (!req_ready);
      sent++;
      if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 16)) @(posedge clock);
      end
   endtask

   // Stop sending and wait until every outstanding response has come back
   task automatic drain_responses();
      req_valid <= 1'b0;
      @(negedge clock);
      while (pending != 0) @(negedge clock);
      @(posedge clock);
   endtask

   task automatic write_threshold(input logic [THRESH_W-1:0] value);
      drain_responses();
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en  <= 1'b0;
      thresh_now = value;
      csr_writes++;
   endtask

   // Hand-picked events at the reset threshold: limit boundaries, wrap, zero touches
   task automatic run_directed();
      send_event(OP_PROFILE, 6'd5, '0);
      send_event(OP_SCHED,   6'd5, 64'd3 << COARSE_SHIFT);
      send_event(OP_START,   6'd5, 64'd1000);
      // hard limit: exactly at it, then one past
      send_event(OP_PROFILE, 6'd5, 64'd1000 + 64'(HARD_LIMIT_RESET));
      send_event(OP_PROFILE, 6'd5, 64'd1001 + 64'(HARD_LIMIT_RESET));
      // soft limit: one past, tick masks the hard check, then exactly at it
      send_event(OP_EXPIRY,  6'd5, (64'd4 + 64'(SOFT_LIMIT_RESET)) << COARSE_SHIFT);
      send_event(OP_PROFILE, 6'd5, '1);
      send_event(OP_PROFILE, 6'd5, '1);
      send_event(OP_EXPIRY,  6'd5, (64'd3 + 64'(SOFT_LIMIT_RESET)) << COARSE_SHIFT);
      // coarse time behind the scheduler touch wraps to a huge difference
      send_event(OP_EXPIRY,  6'd5, 64'd2 << COARSE_SHIFT);
      send_event(OP_CANCEL,  6'd5, '0);
      send_event(OP_PROFILE, 6'd5, '1);
      send_event(OP_PROFILE, 6'd5, '1);
      for (int o = OP_UNUSED_LO; o <= OP_UNUSED_HI; o++)
         send_event(OPCODE_W'(o), 6'd5, '1);
      // top CPU: zero timer touch, maximum timestamps
      send_event(OP_START,   6'd63, '0);
      send_event(OP_PROFILE, 6'd63, '1);
      send_event(OP_SCHED,   6'd63, '1);
      send_event(OP_EXPIRY,  6'd63, '1);
      // CPU 0: no scheduler touch yet, then a real one
      send_event(OP_EXPIRY,  6'd0, 64'd9 << COARSE_SHIFT);
      send_event(OP_SCHED,   6'd0, 64'd1 << COARSE_SHIFT);
      send_event(OP_EXPIRY,  6'd0, 64'd9 << COARSE_SHIFT);
   endtask

   // Mostly monotonic per-CPU event streams on a few busy CPUs, with some noise
   task automatic run_random(input int n);
      logic [OPCODE_W-1:0]  op;
      logic [CPU_IDX_W-1:0] cpu;
      logic [TIME_W-1:0]    hard_lim;
      int                   pick;
      hard_lim = (64'(thresh_now) * 64'd2 + 64'd1) * 64'(FIFTH_SECOND_NS);
      for (int i = 0; i < HOT_CPUS; i++)
         hot_cpu[i] = CPU_IDX_W'($urandom_range(0, DEFAULT_NUM_CPUS - 1));
      for (int i = 0; i < DEFAULT_NUM_CPUS; i++) begin
         case ($urandom_range(0, 7))
            0:       cpu_clock[i] = 64'hFFFF_FFFF_FFFF_FFFF - {$urandom_range(0, 15), $urandom};
            1:       cpu_clock[i] = 64'($urandom);
            default: cpu_clock[i] = {$urandom, $urandom};
         endcase
      end
      for (int i = 0; i < n; i++) begin
         cpu = ($urandom_range(0, 3) != 0) ? hot_cpu[$urandom_range(0, HOT_CPUS - 1)]
                                           : CPU_IDX_W'($urandom_range(0, DEFAULT_NUM_CPUS - 1));
         pick = $urandom_range(0, 99);
         op = (pick < 35) ? OP_PROFILE :
              (pick < 55) ? OP_EXPIRY  :
              (pick < 65) ? OP_START   :
              (pick < 73) ? OP_CANCEL  :
              (pick < 94) ? OP_SCHED   : OPCODE_W'($urandom_range(OP_UNUSED_LO, OP_UNUSED_HI));
         // advance this CPU's time: small, coarse-scale, around the hard limit, not at all, or a jump
         case ($urandom_range(0, 19))
            0, 1, 2, 3, 4, 5: cpu_clock[cpu] += 64'($urandom_range(0, 1 << 20));
            6, 7, 8, 9, 10, 11: cpu_clock[cpu] += {$urandom_range(0, 7), $urandom};
            12, 13, 14, 15: cpu_clock[cpu] += hard_lim + 64'($urandom_range(0, 2)) - 64'd1;
            16, 17, 18: ;
            default: cpu_clock[cpu] = {$urandom, $urandom};
         endcase
         if ($urandom_range(0, 19) == 0)
            send_event(OPCODE_W'($urandom), cpu, {$urandom, $urandom});
         else
            send_event(op, cpu, cpu_clock[cpu]);
      end
   endtask

   function automatic logic [THRESH_W-1:0] phase_threshold(input int p);
      case (p)
         0:       return '0;
         1:       return '1;
         2:       return THRESH_W'(60);
         3:       return THRESH_W'(1);
         4, 5:    return THRESH_W'($urandom_range(0, 63));
         6:       return THRESH_W'(2);
         default: return THRESH_RESET;
      endcase
   endfunction

   // Main sequence
   initial begin
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      run_directed();
      for (int p = 0; p < PHASES; p++) begin
         if (p == PHASES - 1)
            idle_pct = 0;
         else
            case (p % 3)
               0:       idle_pct = 25;
               1:       idle_pct = 0;
               default: idle_pct = 50;
            endcase
         write_threshold(phase_threshold(p));
         run_random(ITEMS_PER_PHASE);
      end
      drain_responses();
      repeat (8) @(posedge clock);
      $display("Sent %0d requests across %0d threshold writes; %0d responses checked.",
               sent, csr_writes, checked);
      $display("Responses with hard-lockup warning: %0d, with soft-lockup warning: %0d.",
               hard_hits, soft_hits);
      if (mismatches == 0 && pending == 0)
         $display("Test completed successfully");
      else
         $display("Test completed with failures");
      $finish;
   end

   // Watchdog on the run itself
   initial begin
      #10_000_000;
      $display("Test completed with failures");
      $finish;
   end

endmodule
